>>> rtl/idea_pkg.sv
// Types and arithmetic helpers for the IDEA round pipeline.
// Modular multiply is split into a product step and a reduction step.
// No dependencies.
package idea_pkg;

  localparam int WordW  = 16;
  localparam int BlockW = 64;
  localparam int InDataW  = 224;
  localparam int NStages  = 8;

  typedef logic [WordW-1:0] word_t;

  // partial multiply mod 2^16+1: raw product, or a finished value when an
  // operand was zero (zero stands for 2^16)
  typedef struct packed {
    logic              sp;
    word_t             sv;
    logic [2*WordW-1:0] prod;
  } mul_t;

  typedef struct packed {
    mul_t  m0;
    mul_t  m3;
    word_t a1;
    word_t a2;
    word_t k5;
    word_t k6;
    logic [BlockW-1:0] ok;
    logic  fin;
  } st0_t;

  typedef struct packed {
    word_t w0, w1, w2, w3;
    word_t xa, xb;
    word_t k5, k6;
    logic [BlockW-1:0] ok;
    logic  fin;
  } st1_t;

  typedef struct packed {
    word_t w0, w1, w2, w3;
    mul_t  ma;
    word_t xb;
    word_t k6;
    logic [BlockW-1:0] ok;
    logic  fin;
  } st2_t;

  typedef struct packed {
    word_t w0, w1, w2, w3;
    word_t maa;
    word_t mbin;
    word_t k6;
    logic [BlockW-1:0] ok;
    logic  fin;
  } st3_t;

  typedef struct packed {
    word_t w0, w1, w2, w3;
    word_t maa;
    mul_t  mb;
    logic [BlockW-1:0] ok;
    logic  fin;
  } st4_t;

  typedef struct packed {
    word_t y0, y1, y2, y3;
    logic [BlockW-1:0] ok;
    logic  fin;
  } st5_t;

  typedef struct packed {
    mul_t  o0;
    word_t o1;
    word_t o2;
    mul_t  o3;
  } st6_t;

  function automatic mul_t mul_start(input word_t a, input word_t b);
    mul_t r;
    r.prod = {{WordW{1'b0}}, a} * {{WordW{1'b0}}, b};
    r.sp   = (a == '0) || (b == '0);
    // 2^16 is -1 mod 2^16+1, so the product is 1 - other operand
    r.sv   = (a == '0) ? word_t'(1) - b : word_t'(1) - a;
    return r;
  endfunction

  function automatic word_t mul_finish(input mul_t m);
    word_t lo;
    word_t hi;
    word_t d;
    lo = m.prod[WordW-1:0];
    hi = m.prod[2*WordW-1:WordW];
    d  = lo - hi + {{(WordW-1){1'b0}}, (lo < hi)};
    return m.sp ? m.sv : d;
  endfunction

  // helper to pass a word through a multiply slot unchanged
  function automatic mul_t mul_pass(input word_t a);
    mul_t r;
    r.sp   = 1'b1;
    r.sv   = a;
    r.prod = '0;
    return r;
  endfunction

endpackage

>>> rtl/idea_cipher_round.sv
// One IDEA cipher round (optionally with the output transformation),
// as an eight-stage pipeline. Depends on idea_pkg.
//
// Usage:
//   Input channel in_*: one request per block. in_tdata carries the block
//   and all subkeys of the round; in_tuser flags the final round, which
//   skips the middle-word swap and applies output keys 7 to 10.
//   Output channel out_*: one 64-bit result block per request, in order.
//   A request passes stages 0 to 7 in order before out_tvalid shows it.
//   Throughput: one block per cycle while out_tready stays high.
//   Each modular multiply takes two stages (16x16 product, then the
//   low-minus-high reduction), and the round has four multiplies in
//   series (key-in, two in the MA structure, output transform), which
//   sets the depth.
//   Stalls: every stage has its own valid bit and loads whenever it is
//   empty or the stage after it moves, so bubbles are squeezed out and
//   in_tready stays high until all eight stages hold data while the
//   receiver stalls. Nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits; data registers
//   are not reset.
module idea_cipher_round (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // low to high: block_in[63:0], main_subkeys[127:64],
  // mixing_subkeys[159:128], output_subkeys[223:160]
  input  logic [idea_pkg::InDataW-1:0]   in_tdata,
  // is_final_round
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // block_out[63:0]
  output logic [idea_pkg::BlockW-1:0]    out_tdata
);
  import idea_pkg::*;

  logic [BlockW-1:0] blk;
  logic [BlockW-1:0] mk;
  logic [31:0]       mx;
  logic [BlockW-1:0] okey;

  logic [NStages-1:0] v_r;
  logic [NStages-1:0] rdy;

  st0_t s0_r, s0_nxt;
  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  st4_t s4_r, s4_nxt;
  st5_t s5_r, s5_nxt;
  st6_t s6_r, s6_nxt;
  logic [BlockW-1:0] s7_r, s7_nxt;

  assign blk  = in_tdata[63:0];
  assign mk   = in_tdata[127:64];
  assign mx   = in_tdata[159:128];
  assign okey = in_tdata[223:160];

  // a stage can load when it is empty or the next one moves
  always_comb begin
    rdy[NStages-1] = !v_r[NStages-1] || out_tready;
    for (int k = NStages - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NStages-1];
  assign out_tdata  = s7_r;

  // stage 0: key-in products for words 0 and 3, adds for words 1 and 2
  always_comb begin
    s0_nxt.m0  = mul_start(blk[63:48], mk[63:48]);
    s0_nxt.m3  = mul_start(blk[15:0], mk[15:0]);
    s0_nxt.a1  = blk[47:32] + mk[47:32];
    s0_nxt.a2  = blk[31:16] + mk[31:16];
    s0_nxt.k5  = mx[31:16];
    s0_nxt.k6  = mx[15:0];
    s0_nxt.ok  = okey;
    s0_nxt.fin = in_tuser;
  end

  // stage 1: reduce, form the MA inputs
  always_comb begin
    s1_nxt.w0  = mul_finish(s0_r.m0);
    s1_nxt.w3  = mul_finish(s0_r.m3);
    s1_nxt.w1  = s0_r.a1;
    s1_nxt.w2  = s0_r.a2;
    s1_nxt.xa  = s1_nxt.w0 ^ s0_r.a2;
    s1_nxt.xb  = s0_r.a1 ^ s1_nxt.w3;
    s1_nxt.k5  = s0_r.k5;
    s1_nxt.k6  = s0_r.k6;
    s1_nxt.ok  = s0_r.ok;
    s1_nxt.fin = s0_r.fin;
  end

  // stage 2: first MA product
  always_comb begin
    s2_nxt.w0  = s1_r.w0;
    s2_nxt.w1  = s1_r.w1;
    s2_nxt.w2  = s1_r.w2;
    s2_nxt.w3  = s1_r.w3;
    s2_nxt.ma  = mul_start(s1_r.xa, s1_r.k5);
    s2_nxt.xb  = s1_r.xb;
    s2_nxt.k6  = s1_r.k6;
    s2_nxt.ok  = s1_r.ok;
    s2_nxt.fin = s1_r.fin;
  end

  // stage 3: reduce, add into second MA input
  always_comb begin
    s3_nxt.w0   = s2_r.w0;
    s3_nxt.w1   = s2_r.w1;
    s3_nxt.w2   = s2_r.w2;
    s3_nxt.w3   = s2_r.w3;
    s3_nxt.maa  = mul_finish(s2_r.ma);
    s3_nxt.mbin = s2_r.xb + s3_nxt.maa;
    s3_nxt.k6   = s2_r.k6;
    s3_nxt.ok   = s2_r.ok;
    s3_nxt.fin  = s2_r.fin;
  end

  // stage 4: second MA product
  always_comb begin
    s4_nxt.w0  = s3_r.w0;
    s4_nxt.w1  = s3_r.w1;
    s4_nxt.w2  = s3_r.w2;
    s4_nxt.w3  = s3_r.w3;
    s4_nxt.maa = s3_r.maa;
    s4_nxt.mb  = mul_start(s3_r.mbin, s3_r.k6);
    s4_nxt.ok  = s3_r.ok;
    s4_nxt.fin = s3_r.fin;
  end

  // stage 5: reduce, finish MA, mix back into the words
  always_comb begin
    word_t mab;
    word_t ma2;
    mab = mul_finish(s4_r.mb);
    ma2 = mab + s4_r.maa;
    s5_nxt.y0  = s4_r.w0 ^ mab;
    s5_nxt.y2  = s4_r.w2 ^ mab;
    s5_nxt.y1  = s4_r.w1 ^ ma2;
    s5_nxt.y3  = s4_r.w3 ^ ma2;
    s5_nxt.ok  = s4_r.ok;
    s5_nxt.fin = s4_r.fin;
  end

  // stage 6: output transform products, or swap of the middle words
  always_comb begin
    if (s5_r.fin) begin
      s6_nxt.o0 = mul_start(s5_r.y0, s5_r.ok[63:48]);
      s6_nxt.o1 = s5_r.y1 + s5_r.ok[47:32];
      s6_nxt.o2 = s5_r.y2 + s5_r.ok[31:16];
      s6_nxt.o3 = mul_start(s5_r.y3, s5_r.ok[15:0]);
    end else begin
      s6_nxt.o0 = mul_pass(s5_r.y0);
      s6_nxt.o1 = s5_r.y2;
      s6_nxt.o2 = s5_r.y1;
      s6_nxt.o3 = mul_pass(s5_r.y3);
    end
  end

  // stage 7: final reduction, output register
  assign s7_nxt = {mul_finish(s6_r.o0), s6_r.o1, s6_r.o2, mul_finish(s6_r.o3)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NStages; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) s0_r <= s0_nxt;
    if (rdy[1]) s1_r <= s1_nxt;
    if (rdy[2]) s2_r <= s2_nxt;
    if (rdy[3]) s3_r <= s3_nxt;
    if (rdy[4]) s4_r <= s4_nxt;
    if (rdy[5]) s5_r <= s5_nxt;
    if (rdy[6]) s6_r <= s6_nxt;
    if (rdy[7]) s7_r <= s7_nxt;
  end

  // no results right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // an empty output stage lets the whole pipe move
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  // full pipe with stalled receiver must back-pressure the input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_tready |-> !in_tready)
    else $error("input accepted into a full stalled pipe");

  // an accepted request occupies stage 0 on the next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted request lost at stage 0");

  // a stalled output stage keeps its result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && (s7_r == $past(s7_r)))
    else $error("stalled result changed");

endmodule
